@@ hw/rtl/bgi_pkg.sv @@
// Shared types and constants of the bilinear grid interpolator.
package bgi_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    typedef enum logic [2:0] {
        REG_X_LOW      = 3'd0,
        REG_X_HIGH     = 3'd1,
        REG_Y_LOW      = 3'd2,
        REG_Y_HIGH     = 3'd3,
        REG_INV_STEP_X = 3'd4,
        REG_INV_STEP_Y = 3'd5,
        REG_ROWS_USED  = 3'd6,
        REG_COLS_USED  = 3'd7
    } cfg_reg_e;

    // rows_used and cols_used hold the clamped point counts
    typedef struct packed {
        logic signed [DATA_W-1:0] x_low;
        logic signed [DATA_W-1:0] x_high;
        logic signed [DATA_W-1:0] y_low;
        logic signed [DATA_W-1:0] y_high;
        logic [DATA_W-1:0]        inv_step_x;
        logic [DATA_W-1:0]        inv_step_y;
        logic [CNT_W-1:0]         rows_used;
        logic [CNT_W-1:0]         cols_used;
    } cfg_t;

endpackage

@@ hw/rtl/bgi_ifs.sv @@
// Channel interfaces: command items, results and configuration writes.
interface bgi_in_if import bgi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic [5:0]               row_index;
    logic [5:0]               col_index;
    logic signed [DATA_W-1:0] sample_value;

    modport source (
        output valid, func, point_x, point_y, row_index, col_index, sample_value,
        input  ready
    );
    modport sink (
        input  valid, func, point_x, point_y, row_index, col_index, sample_value,
        output ready
    );
endinterface

interface bgi_out_if import bgi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] interp_value;
    logic                     outside;

    modport source (
        output valid, interp_value, outside,
        input  ready
    );
    modport sink (
        input  valid, interp_value, outside,
        output ready
    );
endinterface

interface bgi_cfg_if import bgi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        index;
    logic [DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ hw/rtl/bgi_cfg.sv @@
// Configuration register file with clamping of the grid point counts.
module bgi_cfg import bgi_pkg::*; #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    bgi_cfg_if.sink cfg,
    output cfg_t   regs
);

    localparam logic [CNT_W-1:0] ROWS_RST = CNT_W'((GRID_ROWS < 64) ? GRID_ROWS : 64);
    localparam logic [CNT_W-1:0] COLS_RST = CNT_W'((GRID_COLS < 64) ? GRID_COLS : 64);

    cfg_t regs_reg;
    cfg_t regs_next;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v, input int top);
        logic [CNT_W-1:0] r;
        if (v < CNT_W'(2))
        begin
            r = CNT_W'(2);
        end
        else if (int'(v) > top)
        begin
            r = CNT_W'(top);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg_reg_e'(cfg.index))
                REG_X_LOW:      regs_next.x_low      = $signed(cfg.data);
                REG_X_HIGH:     regs_next.x_high     = $signed(cfg.data);
                REG_Y_LOW:      regs_next.y_low      = $signed(cfg.data);
                REG_Y_HIGH:     regs_next.y_high     = $signed(cfg.data);
                REG_INV_STEP_X: regs_next.inv_step_x = cfg.data;
                REG_INV_STEP_Y: regs_next.inv_step_y = cfg.data;
                REG_ROWS_USED:  regs_next.rows_used  = clamp_count(cfg.data[CNT_W-1:0], GRID_ROWS);
                REG_COLS_USED:  regs_next.cols_used  = clamp_count(cfg.data[CNT_W-1:0], GRID_COLS);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.x_low      <= '0;
            regs_reg.x_high     <= 32'sh0001_0000;
            regs_reg.y_low      <= '0;
            regs_reg.y_high     <= 32'sh0001_0000;
            regs_reg.inv_step_x <= 32'h0001_0000;
            regs_reg.inv_step_y <= 32'h0001_0000;
            regs_reg.rows_used  <= ROWS_RST;
            regs_reg.cols_used  <= COLS_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ hw/rtl/bgi_bank.sv @@
// One bank of the grid store: simple dual-port RAM with registered read.
module bgi_bank import bgi_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bilinear_grid_interpolator_core.sv @@
// Bilinear interpolation over a regular grid of Q16.16 samples. The block takes one item
// per cycle while ready is high, write or evaluate, in any mix; each evaluate returns one
// result, writes return nothing. The rate is set by the grid store, which is split into
// four banks by row and column parity so that the four corners of a cell are read together,
// one read port per bank; a write occupies the same memory stage, so a write is seen by
// every evaluate accepted after it. Results pass through a two-entry output queue, so the
// block keeps accepting while one result waits; ready drops only when both are full.
// The store needs no clearing after reset: an entry must be written before it is read.
module bilinear_grid_interpolator_core import bgi_pkg::*; #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    bgi_cfg_if.sink   cfg,
    bgi_in_if.sink    item,
    bgi_out_if.source result
);

    localparam int CELL_W     = $clog2(GRID_ROWS);
    localparam int CELL_C_W   = $clog2(GRID_COLS);
    localparam int HALF_ROWS  = (GRID_ROWS + 1) / 2;
    localparam int HALF_COLS  = (GRID_COLS + 1) / 2;
    localparam int BANK_DEPTH = HALF_ROWS * HALF_COLS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int LIN_W      = CELL_W + CELL_C_W + 7;
    localparam int NUM_BANKS  = 4;
    localparam int STAGES     = 8;

    localparam logic [16:0]        ONE_Q16    = 17'd65536;
    localparam logic signed [65:0] ROUND_HALF = 66'sd2147483648;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic [5:0]               row;
        logic [5:0]               col;
        logic [DATA_W-1:0]        data;
    } s1_t;

    typedef struct packed {
        logic              func;
        logic              outside;
        logic [DATA_W-1:0] dx;
        logic [DATA_W-1:0] dy;
        logic [5:0]        row;
        logic [5:0]        col;
        logic [DATA_W-1:0] data;
    } s2_t;

    typedef struct packed {
        logic              func;
        logic              outside;
        logic [63:0]       qx;
        logic [63:0]       qy;
        logic [5:0]        row;
        logic [5:0]        col;
        logic [DATA_W-1:0] data;
    } s3_t;

    typedef struct packed {
        logic                func;
        logic                outside;
        logic [CELL_W-1:0]   i;
        logic [CELL_C_W-1:0] j;
        logic [16:0]         s;
        logic [16:0]         t;
        logic [5:0]          row;
        logic [5:0]          col;
        logic [DATA_W-1:0]   data;
    } s4_t;

    typedef struct packed {
        logic        func;
        logic        outside;
        logic        i0;
        logic        j0;
        logic [33:0] w00;
        logic [33:0] w01;
        logic [33:0] w10;
        logic [33:0] w11;
    } s5_t;

    typedef struct packed {
        logic               func;
        logic               outside;
        logic signed [65:0] p00;
        logic signed [65:0] p01;
        logic signed [65:0] p10;
        logic signed [65:0] p11;
    } s6_t;

    typedef struct packed {
        logic               func;
        logic               outside;
        logic signed [65:0] sum_a;
        logic signed [65:0] sum_b;
    } s7_t;

    typedef struct packed {
        logic                     func;
        logic                     outside;
        logic signed [DATA_W-1:0] value;
    } s8_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     outside;
    } res_t;

    cfg_t cfg_q;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    s6_t s6_reg, s6_next;
    s7_t s7_reg, s7_next;
    s8_t s8_reg, s8_next;

    logic out_valid_reg, out_valid_next;
    logic spare_valid_reg, spare_valid_next;
    res_t out_reg, out_next;
    res_t spare_reg, spare_next;

    logic adv;
    logic push;
    logic pop;
    logic wr_go;

    logic [NUM_BANKS-1:0] bank_wr_en;
    logic [BANK_AW-1:0]   bank_wr_addr;
    logic [BANK_AW-1:0]   bank_rd_addr [NUM_BANKS];
    logic [DATA_W-1:0]    bank_rd_data [NUM_BANKS];

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [LIN_W-1:0] r,
                                                     input logic [LIN_W-1:0] c);
        logic [LIN_W-1:0] lin;
        lin = (r >> 1) * LIN_W'(HALF_COLS) + (c >> 1);
        return lin[BANK_AW-1:0];
    endfunction

    bgi_cfg #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_q)
    );

    // the whole pipeline holds only when both queue entries are taken
    assign adv        = !spare_valid_reg;
    assign item.ready = adv;
    assign push       = adv && valid_reg[STAGES-1] && (s8_reg.func == FUNC_EVAL);
    assign pop        = out_valid_reg && result.ready;

    assign valid_next = adv ? {valid_reg[STAGES-2:0], item.valid} : valid_reg;

    // stage 1 to 2: bounds check and offset from the low corner
    always_comb
    begin
        s1_next.func = item.func;
        s1_next.px   = item.point_x;
        s1_next.py   = item.point_y;
        s1_next.row  = item.row_index;
        s1_next.col  = item.col_index;
        s1_next.data = item.sample_value;

        s2_next.func    = s1_reg.func;
        s2_next.outside = ($signed(s1_reg.px) <  cfg_q.x_low)
                       || ($signed(s1_reg.px) >= cfg_q.x_high)
                       || ($signed(s1_reg.py) <  cfg_q.y_low)
                       || ($signed(s1_reg.py) >= cfg_q.y_high);
        s2_next.dx      = s1_reg.px - cfg_q.x_low;
        s2_next.dy      = s1_reg.py - cfg_q.y_low;
        s2_next.row     = s1_reg.row;
        s2_next.col     = s1_reg.col;
        s2_next.data    = s1_reg.data;
    end

    // stage 2 to 3: scale by the reciprocal cell size
    always_comb
    begin
        s3_next.func    = s2_reg.func;
        s3_next.outside = s2_reg.outside;
        s3_next.qx      = s2_reg.dx * cfg_q.inv_step_x;
        s3_next.qy      = s2_reg.dy * cfg_q.inv_step_y;
        s3_next.row     = s2_reg.row;
        s3_next.col     = s2_reg.col;
        s3_next.data    = s2_reg.data;
    end

    // stage 3 to 4: split into cell and fraction, pin to the last grid line past the end
    always_comb
    begin
        logic sat_x;
        logic sat_y;
        sat_x = s3_reg.qx[63:32] >= {25'd0, cfg_q.rows_used - 7'd1};
        sat_y = s3_reg.qy[63:32] >= {25'd0, cfg_q.cols_used - 7'd1};

        s4_next.func    = s3_reg.func;
        s4_next.outside = s3_reg.outside;
        s4_next.i       = sat_x ? CELL_W'(cfg_q.rows_used - 7'd2) : s3_reg.qx[32 +: CELL_W];
        s4_next.j       = sat_y ? CELL_C_W'(cfg_q.cols_used - 7'd2) : s3_reg.qy[32 +: CELL_C_W];
        s4_next.s       = sat_x ? ONE_Q16 : {1'b0, s3_reg.qx[31:16]};
        s4_next.t       = sat_y ? ONE_Q16 : {1'b0, s3_reg.qy[31:16]};
        s4_next.row     = s3_reg.row;
        s4_next.col     = s3_reg.col;
        s4_next.data    = s3_reg.data;
    end

    // stage 4: memory access (corner reads or one write) and corner weights
    always_comb
    begin
        logic [16:0] ns;
        logic [16:0] nt;
        ns = ONE_Q16 - s4_reg.s;
        nt = ONE_Q16 - s4_reg.t;

        s5_next.func    = s4_reg.func;
        s5_next.outside = s4_reg.outside;
        s5_next.i0      = s4_reg.i[0];
        s5_next.j0      = s4_reg.j[0];
        s5_next.w00     = ns * nt;
        s5_next.w01     = ns * s4_reg.t;
        s5_next.w10     = s4_reg.s * nt;
        s5_next.w11     = s4_reg.s * s4_reg.t;
    end

    assign wr_go = adv && valid_reg[3] && (s4_reg.func == FUNC_WRITE)
                && (int'(s4_reg.row) < GRID_ROWS) && (int'(s4_reg.col) < GRID_COLS);
    assign bank_wr_addr = bank_addr(LIN_W'(s4_reg.row), LIN_W'(s4_reg.col));

    always_comb
    begin
        logic             br;
        logic             bc;
        logic [LIN_W-1:0] rr;
        logic [LIN_W-1:0] cc;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            br = b[1];
            bc = b[0];
            // a bank whose parity differs from the cell's holds the next line
            rr = LIN_W'(s4_reg.i) + LIN_W'(br ^ s4_reg.i[0]);
            cc = LIN_W'(s4_reg.j) + LIN_W'(bc ^ s4_reg.j[0]);
            bank_rd_addr[b] = bank_addr(rr, cc);
            bank_wr_en[b]   = wr_go && (s4_reg.row[0] == br) && (s4_reg.col[0] == bc);
        end
    end

    generate
        for (genvar g = 0; g < NUM_BANKS; g++)
        begin : g_bank
            bgi_bank #(
                .DEPTH (BANK_DEPTH),
                .AW    (BANK_AW)
            ) u_bank (
                .clk     (clk),
                .wr_en   (bank_wr_en[g]),
                .wr_addr (bank_wr_addr),
                .wr_data (s4_reg.data),
                .rd_en   (adv),
                .rd_addr (bank_rd_addr[g]),
                .rd_data (bank_rd_data[g])
            );
        end
    endgenerate

    // stage 5 to 6: route banks to corners and weight them
    always_comb
    begin
        logic signed [DATA_W-1:0] v00;
        logic signed [DATA_W-1:0] v01;
        logic signed [DATA_W-1:0] v10;
        logic signed [DATA_W-1:0] v11;
        v00 = $signed(bank_rd_data[{s5_reg.i0, s5_reg.j0}]);
        v01 = $signed(bank_rd_data[{s5_reg.i0, !s5_reg.j0}]);
        v10 = $signed(bank_rd_data[{!s5_reg.i0, s5_reg.j0}]);
        v11 = $signed(bank_rd_data[{!s5_reg.i0, !s5_reg.j0}]);

        s6_next.func    = s5_reg.func;
        s6_next.outside = s5_reg.outside;
        s6_next.p00     = $signed({1'b0, s5_reg.w00}) * v00;
        s6_next.p01     = $signed({1'b0, s5_reg.w01}) * v01;
        s6_next.p10     = $signed({1'b0, s5_reg.w10}) * v10;
        s6_next.p11     = $signed({1'b0, s5_reg.w11}) * v11;
    end

    // stages 6 to 8: add the four terms, round to nearest by flooring after half
    always_comb
    begin
        logic signed [65:0] total;

        s7_next.func    = s6_reg.func;
        s7_next.outside = s6_reg.outside;
        s7_next.sum_a   = s6_reg.p00 + s6_reg.p01;
        s7_next.sum_b   = s6_reg.p10 + s6_reg.p11;

        total           = s7_reg.sum_a + s7_reg.sum_b + ROUND_HALF;
        s8_next.func    = s7_reg.func;
        s8_next.outside = s7_reg.outside;
        s8_next.value   = s7_reg.outside ? '0 : $signed(total[63:32]);
    end

    // two-entry output queue
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        spare_valid_next = spare_valid_reg;
        out_next         = out_reg;
        spare_next       = spare_reg;
        if (!out_valid_reg || pop)
        begin
            if (spare_valid_reg)
            begin
                out_valid_next   = 1'b1;
                out_next         = spare_reg;
                spare_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next   = push;
                out_next.value   = s8_reg.value;
                out_next.outside = s8_reg.outside;
            end
        end
        else if (push)
        begin
            spare_valid_next   = 1'b1;
            spare_next.value   = s8_reg.value;
            spare_next.outside = s8_reg.outside;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.interp_value = out_reg.value;
    assign result.outside      = out_reg.outside;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        spare_reg <= spare_next;
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
            s8_reg <= s8_next;
        end
    end

endmodule

@@ hw/rtl/bgi_checker.sv @@
// Port-level checks for the interpolator core, bound into the core module.
module bgi_checker import bgi_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              item_func,
    input logic              result_valid,
    input logic              result_ready,
    input logic [DATA_W-1:0] interp_value,
    input logic              outside
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;

    // evaluate beats taken but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (item_valid && item_ready && (item_func == FUNC_EVAL))
        begin
            pending_next = pending_next + 8'd1;
        end
        if (result_valid && result_ready)
        begin
            pending_next = pending_next - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(interp_value) && $stable(outside))
        else $error("result payload changed while stalled");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && outside |-> interp_value == '0)
        else $error("outside point returned a non-zero value");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 8'd0)
        else $error("result beat without an evaluate beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("input stalled with no result waiting");

endmodule

bind bilinear_grid_interpolator_core bgi_checker u_bgi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_func    (item.func),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .interp_value (result.interp_value),
    .outside      (result.outside)
);

@@ test/bgi_interp_checker.sv @@
// Watches the channels of the bilinear grid interpolator, predicts each result and compares.
module bgi_interp_checker import bgi_pkg::*; #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  logic clk,
    input  logic rst_n,
    bgi_cfg_if   cfg,
    bgi_in_if    item,
    bgi_out_if   result,
    output int   mismatches,
    output int   open_results
);

    localparam int unsigned ONE_Q16 = 65536;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     outside;
    } interp_t;

    cfg_t                     regs_m;
    logic signed [DATA_W-1:0] grid_m [GRID_ROWS][GRID_COLS];
    interp_t                  interp_due [$];
    interp_t                  oldest;

    function automatic int unsigned used_points(logic [CNT_W-1:0] raw, int unsigned top);
        if (raw < 2)
            return 2;
        if (raw > top)
            return top;
        return 32'(raw);
    endfunction

    // Scale the offset, then split it into cell and Q0.16 fraction; pin the tail to the last line
    function automatic void locate_cell(input logic [31:0] offset, input logic [31:0] inv,
                                        input int unsigned count, output int unsigned cell_idx,
                                        output int unsigned frac);
        logic [63:0] q;
        q = {32'd0, offset} * {32'd0, inv};
        if (q[63:32] >= count - 1)
        begin
            cell_idx = count - 2;
            frac     = ONE_Q16;
        end
        else
        begin
            cell_idx = q[63:32];
            frac     = 32'(q[31:16]);
        end
    endfunction

    function automatic interp_t interpolate(logic signed [DATA_W-1:0] px,
                                            logic signed [DATA_W-1:0] py);
        interp_t     r;
        int unsigned rows;
        int unsigned cols;
        int unsigned i;
        int unsigned j;
        int unsigned s;
        int unsigned t;
        logic [31:0] off_x;
        logic [31:0] off_y;
        longint      acc;
        longint      res;
        r.value   = '0;
        r.outside = 1'b1;
        if (px < regs_m.x_low || px >= regs_m.x_high || py < regs_m.y_low || py >= regs_m.y_high)
            return r;
        rows  = used_points(regs_m.rows_used, GRID_ROWS);
        cols  = used_points(regs_m.cols_used, GRID_COLS);
        off_x = px - regs_m.x_low;
        off_y = py - regs_m.y_low;
        locate_cell(off_x, regs_m.inv_step_x, rows, i, s);
        locate_cell(off_y, regs_m.inv_step_y, cols, j, t);
        acc = longint'(ONE_Q16 - s) * longint'(ONE_Q16 - t) * longint'(grid_m[i][j])
            + longint'(ONE_Q16 - s) * longint'(t) * longint'(grid_m[i][j+1])
            + longint'(s) * longint'(ONE_Q16 - t) * longint'(grid_m[i+1][j])
            + longint'(s) * longint'(t) * longint'(grid_m[i+1][j+1]);
        // round half up to Q16.16
        res = (acc + 64'sh8000_0000) >>> 32;
        r.value   = res[31:0];
        r.outside = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_m.x_low      = '0;
            regs_m.x_high     = 32'h0001_0000;
            regs_m.y_low      = '0;
            regs_m.y_high     = 32'h0001_0000;
            regs_m.inv_step_x = 32'h0001_0000;
            regs_m.inv_step_y = 32'h0001_0000;
            regs_m.rows_used  = 7'd64;
            regs_m.cols_used  = 7'd64;
            interp_due.delete();
            mismatches   = 0;
            open_results = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_X_LOW:      regs_m.x_low      = cfg.data;
                    REG_X_HIGH:     regs_m.x_high     = cfg.data;
                    REG_Y_LOW:      regs_m.y_low      = cfg.data;
                    REG_Y_HIGH:     regs_m.y_high     = cfg.data;
                    REG_INV_STEP_X: regs_m.inv_step_x = cfg.data;
                    REG_INV_STEP_Y: regs_m.inv_step_y = cfg.data;
                    REG_ROWS_USED:  regs_m.rows_used  = cfg.data[CNT_W-1:0];
                    REG_COLS_USED:  regs_m.cols_used  = cfg.data[CNT_W-1:0];
                    default: ;
                endcase
            end
            // compare before queueing, so a beat can never be matched to its own prediction
            if (result.valid && result.ready)
            begin
                if (interp_due.size() == 0)
                begin
                    $error("result beat with no evaluate pending: interp_value %0d outside %0b",
                           result.interp_value, result.outside);
                    mismatches++;
                end
                else
                begin
                    oldest = interp_due.pop_front();
                    if (result.interp_value !== oldest.value)
                    begin
                        $error("interp_value: expected %0d, actual %0d",
                               oldest.value, result.interp_value);
                        mismatches++;
                    end
                    if (result.outside !== oldest.outside)
                    begin
                        $error("outside: expected %0b, actual %0b",
                               oldest.outside, result.outside);
                        mismatches++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                if (item.func == FUNC_WRITE)
                    grid_m[item.row_index][item.col_index] = item.sample_value;
                else
                    interp_due.insert(interp_due.size(),
                                      interpolate(item.point_x, item.point_y));
            end
            open_results = interp_due.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// Top of the interpolator testbench: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
    import bgi_pkg::*;

    localparam int GRID_ROWS       = 64;
    localparam int GRID_COLS       = 64;
    localparam int RESET_CYCLES    = 12;
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int MAX_GAP         = 18;
    localparam int LATENCY_PAD     = 12;
    localparam int LONG_HOLD       = 300;
    localparam int CYCLE_LIMIT     = 1_000_000;

    logic clk = 1'b0;
    logic rst_n;

    bgi_cfg_if cfg_bus ();
    bgi_in_if  cmd_bus ();
    bgi_out_if res_bus ();

    int          mismatches;
    int          open_results;
    int          cycles = 0;
    bit          idle_on;
    bit          hold_request;
    bit          hold_served;
    cfg_t        setting;
    int unsigned rows_eff;
    int unsigned cols_eff;

    bilinear_grid_interpolator_core #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (cmd_bus),
        .result (res_bus)
    );

    bgi_interp_checker #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) interp_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_bus),
        .item         (cmd_bus),
        .result       (res_bus),
        .mismatches   (mismatches),
        .open_results (open_results)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("bilinear_grid_interpolator_core verification failed");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        res_bus.ready = 1'b0;
        hold_served   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_served)
            begin
                res_bus.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_served   = 1'b1;
                res_bus.ready = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_bus.ready = 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
                res_bus.ready = 1'b1;
            end
            else
            begin
                res_bus.ready = 1'b1;
            end
        end
    end

    function automatic int unsigned used_points(logic [CNT_W-1:0] raw, int unsigned top);
        if (raw < 2)
            return 2;
        if (raw > top)
            return top;
        return 32'(raw);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return CNT_W'($urandom_range(0, 1));
            1:       return CNT_W'($urandom_range(64, 127));
            default: return CNT_W'($urandom_range(2, 9));
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3, 4:    return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_coord(logic signed [31:0] lo,
                                                      logic signed [31:0] hi, bit want_inside);
        longint      span;
        logic [63:0] r64;
        span = longint'(hi) - longint'(lo);
        r64  = {$urandom, $urandom};
        if (want_inside && span > 0)
        begin
            case ($urandom_range(0, 7))
                0:       return lo;
                1:       return 32'(longint'(hi) - 1);
                default: return 32'(longint'(lo) + longint'(r64 % 64'(span)));
            endcase
        end
        case ($urandom_range(0, 5))
            0:       return lo - 32'sd1;
            1:       return hi;
            2:       return 32'sh8000_0000;
            3:       return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Bounds and reciprocal for one axis; the reciprocal mostly just covers the grid
    task automatic pick_axis(input int unsigned count, output logic signed [31:0] lo,
                             output logic signed [31:0] hi, output logic [31:0] inv);
        longint      span;
        longint      lo_l;
        longint      hi_l;
        logic [63:0] fit;
        case ($urandom_range(0, 3))
            0:       span = longint'($urandom_range(1, 4096));
            1, 2:    span = longint'($urandom_range(1 << 16, 1 << 24));
            default: span = longint'($urandom) | 1;
        endcase
        case ($urandom_range(0, 3))
            0:       lo_l = -64'sd2147483648;
            1:       lo_l = 0;
            default: lo_l = longint'($signed($urandom));
        endcase
        hi_l = lo_l + span;
        if (hi_l > 64'sd2147483647)
        begin
            hi_l = 64'sd2147483647;
            lo_l = hi_l - span;
        end
        // now and then an empty or inverted box
        if ($urandom_range(0, 11) == 0)
        begin
            hi_l = lo_l - longint'($urandom_range(0, 1000));
            if (hi_l < -64'sd2147483648)
                hi_l = lo_l;
        end
        fit = (64'(count - 1) << 32) / 64'(span);
        case ($urandom_range(0, 9))
            0:       inv = '0;
            1:       inv = $urandom;
            2:       inv = 32'hFFFF_FFFF;
            default:
            begin
                fit = fit + 64'($urandom_range(0, 3));
                inv = (fit > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fit[31:0];
            end
        endcase
        lo = lo_l[31:0];
        hi = hi_l[31:0];
    endtask

    task automatic phase_setting(input int k, output cfg_t s);
        case (k)
            0:
            begin
                s.rows_used = 7'd127;
                s.cols_used = 7'd2;
            end
            1:
            begin
                s.rows_used = 7'd0;
                s.cols_used = 7'd64;
            end
            2:
            begin
                s.rows_used = 7'd3;
                s.cols_used = 7'd3;
            end
            3:
            begin
                s.rows_used = 7'd1;
                s.cols_used = 7'd65;
            end
            default:
            begin
                s.rows_used = pick_count();
                s.cols_used = pick_count();
                if (used_points(s.rows_used, GRID_ROWS) * used_points(s.cols_used, GRID_COLS) > 160)
                    s.cols_used = 7'd2;
            end
        endcase
        pick_axis(used_points(s.rows_used, GRID_ROWS), s.x_low, s.x_high, s.inv_step_x);
        pick_axis(used_points(s.cols_used, GRID_COLS), s.y_low, s.y_high, s.inv_step_y);
        case (k)
            0:
            begin
                s.x_low      = 32'sh8000_0000;
                s.x_high     = 32'sh7FFF_FFFF;
                s.inv_step_x = 32'd64;
            end
            1:
            begin
                s.inv_step_x = 32'hFFFF_FFFF;
                s.y_low      = 32'sh8000_0000;
                s.y_high     = 32'sh7FFF_FFFF;
                s.inv_step_y = 32'd64;
            end
            2:
            begin
                s.x_high     = s.x_low;
                s.inv_step_y = '0;
            end
            3:
            begin
                s.inv_step_x = '0;
                s.inv_step_y = '0;
            end
            default: ;
        endcase
    endtask

    // Called and returns at a falling edge; valid stays high for a following beat
    task automatic send_item(input logic f, input logic signed [31:0] px,
                             input logic signed [31:0] py, input logic [5:0] r,
                             input logic [5:0] c, input logic signed [31:0] v);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid = 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
        end
        cmd_bus.valid        = 1'b1;
        cmd_bus.func         = f;
        cmd_bus.point_x      = px;
        cmd_bus.point_y      = py;
        cmd_bus.row_index    = r;
        cmd_bus.col_index    = c;
        cmd_bus.sample_value = v;
        do @(posedge clk); while (!cmd_bus.ready);
        @(negedge clk);
    endtask

    task automatic write_entry(input int r, input int c, input logic signed [31:0] v);
        send_item(FUNC_WRITE, $urandom, $urandom, 6'(r), 6'(c), v);
    endtask

    task automatic eval_point(input logic signed [31:0] px, input logic signed [31:0] py);
        send_item(FUNC_EVAL, px, py, 6'($urandom), 6'($urandom), $urandom);
    endtask

    task automatic cfg_beat(input cfg_reg_e idx, input logic [31:0] d);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = d;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
    endtask

    task automatic apply_setting(input cfg_t s);
        cfg_beat(REG_X_LOW, s.x_low);
        cfg_beat(REG_X_HIGH, s.x_high);
        cfg_beat(REG_Y_LOW, s.y_low);
        cfg_beat(REG_Y_HIGH, s.y_high);
        cfg_beat(REG_INV_STEP_X, s.inv_step_x);
        cfg_beat(REG_INV_STEP_Y, s.inv_step_y);
        cfg_beat(REG_ROWS_USED, 32'(s.rows_used));
        cfg_beat(REG_COLS_USED, 32'(s.cols_used));
        cfg_bus.valid = 1'b0;
        setting  = s;
        rows_eff = used_points(s.rows_used, GRID_ROWS);
        cols_eff = used_points(s.cols_used, GRID_COLS);
    endtask

    // Hold the input until every evaluate has come back, then let trailing writes settle
    task automatic drain();
        cmd_bus.valid = 1'b0;
        while (open_results != 0) @(negedge clk);
        repeat (LATENCY_PAD) @(negedge clk);
    endtask

    task automatic fill_region();
        for (int r = 0; r < rows_eff; r++)
            for (int c = 0; c < cols_eff; c++)
                write_entry(r, c, pick_value());
    endtask

    task automatic send_random();
        int sel;
        bit ox;
        bit oy;
        if ($urandom_range(0, 3) == 0)
        begin
            write_entry($urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1),
                        pick_value());
        end
        else
        begin
            ox = 1'b0;
            oy = 1'b0;
            if ($urandom_range(0, 4) == 0)
            begin
                sel = $urandom_range(0, 2);
                ox  = (sel != 1);
                oy  = (sel != 0);
            end
            eval_point(pick_coord(setting.x_low, setting.x_high, !ox),
                       pick_coord(setting.y_low, setting.y_high, !oy));
        end
    endtask

    initial
    begin
        cfg_t next_setting;
        rst_n                = 1'b0;
        idle_on              = 1'b1;
        hold_request         = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = '0;
        cfg_bus.data         = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.func         = FUNC_WRITE;
        cmd_bus.point_x      = '0;
        cmd_bus.point_y      = '0;
        cmd_bus.row_index    = '0;
        cmd_bus.col_index    = '0;
        cmd_bus.sample_value = '0;
        setting.x_low        = '0;
        setting.x_high       = 32'h0001_0000;
        setting.y_low        = '0;
        setting.y_high       = 32'h0001_0000;
        setting.inv_step_x   = 32'h0001_0000;
        setting.inv_step_y   = 32'h0001_0000;
        setting.rows_used    = 7'd64;
        setting.cols_used    = 7'd64;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Reset bounds span one cell, so only the corner cell is read
        write_entry(0, 0, 32'sh7FFF_FFFF);
        write_entry(0, 1, 32'sh8000_0000);
        write_entry(1, 0, 32'sh0000_0000);
        write_entry(1, 1, 32'shFFFF_0000);
        write_entry(63, 63, 32'sh0003_8000);
        eval_point(32'sh0000_0000, 32'sh0000_0000);
        eval_point(32'sh0000_FFFF, 32'sh0000_FFFF);
        eval_point(32'sh0000_8000, 32'sh0000_8000);
        eval_point(32'sh0000_0000, 32'sh0000_FFFF);
        eval_point(32'sh0000_FFFF, 32'sh0000_0000);
        eval_point(32'sh0000_4000, 32'sh0000_C000);
        eval_point(-32'sd1, 32'sh0000_0000);
        eval_point(32'sh0001_0000, 32'sh0000_0000);
        eval_point(32'sh0000_0000, -32'sd1);
        eval_point(32'sh0000_0000, 32'sh0001_0000);
        eval_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        eval_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        write_entry(0, 0, 32'sh0000_0000);
        eval_point(32'sh0000_0001, 32'sh0000_0001);

        for (int k = 0; k < PHASES; k++)
        begin
            drain();
            // one stretch without idling mid-run, and none at all in the last phase
            idle_on = (k != 5) && (k != PHASES - 1);
            phase_setting(k, next_setting);
            apply_setting(next_setting);
            fill_region();
            if (k == 6)
                hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (k == 7 && n == 50)
                    drain();
                send_random();
            end
        end
        drain();

        if (mismatches == 0)
            $display("bilinear_grid_interpolator_core verification clean");
        else
            $display("bilinear_grid_interpolator_core verification failed");
        $finish;
    end

endmodule
